>>> rtl/lbs_pkg.sv
`timescale 1ns / 1ps
package lbs_pkg;

  localparam int BONE_SLOTS  = 64;
  localparam int SLOT_W      = 6;
  localparam int INFLUENCES  = 4;
  localparam int BEAT_W      = 2;
  localparam int FRAC_BITS   = 16;
  localparam int WEIGHT_FRAC = 15;
  localparam int ROW_WORDS   = 13;
  localparam int MTX_WORDS   = 12;
  localparam int WSEL_W      = 4;
  localparam int DATA_W      = 32;
  localparam int WT_W        = 16;
  localparam int PROD_W      = DATA_W + WT_W + 1;
  localparam int ACC_W       = PROD_W + 2;

  localparam logic [WSEL_W-1:0] MARGIN_WORD = WSEL_W'(MTX_WORDS);
  localparam logic [WT_W-1:0]   WEIGHT_ONE  = WT_W'(1 << WEIGHT_FRAC);

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_SKIN = 1'b1
  } cmd_e;

  typedef logic [ROW_WORDS-1:0][DATA_W-1:0] bone_row_t;

  // one influence beat moving down the pipe
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } beat_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sh0000_0000_7FFF_FFFF;
    lo = -64'sh0000_0000_8000_0000;
    if (v > hi) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[DATA_W-1:0];
    end
  endfunction

endpackage

>>> rtl/linear_blend_vertex_skinning.sv
`timescale 1ns / 1ps
// channel | handshake            | words
// in      | in_valid_i/in_ready_o | command, bone_slot, word_select, word_value, rest, weights, idx
// out     | out_valid_o/out_ready_i | skinned_x/y/z, blended_margin
// A load writes one table word; a skin reads one bone row per influence from the bone
// table, one row per cycle while the output is not held, then four more stages to the output register.
// Reset clears control only; the bone table is undefined until loaded.
// A held output word freezes the whole pipe; nothing is dropped or replayed.
module linear_blend_vertex_skinning import lbs_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [0:0]                command_i,
  input  logic [SLOT_W-1:0]         bone_slot_i,
  input  logic [WSEL_W-1:0]         word_select_i,
  input  logic signed [DATA_W-1:0]  word_value_i,
  input  logic signed [DATA_W-1:0]  rest_x_i,
  input  logic signed [DATA_W-1:0]  rest_y_i,
  input  logic signed [DATA_W-1:0]  rest_z_i,
  input  logic [4*WT_W-1:0]         weights_packed_i,
  input  logic [4*SLOT_W-1:0]       bone_indices_packed_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [DATA_W-1:0]  skinned_x_o,
  output logic signed [DATA_W-1:0]  skinned_y_o,
  output logic signed [DATA_W-1:0]  skinned_z_o,
  output logic signed [DATA_W-1:0]  blended_margin_o
);

  logic                     hold_q;
  cmd_e                     cmd_q;
  logic [SLOT_W-1:0]        slot_q;
  logic [WSEL_W-1:0]        wsel_q;
  logic [DATA_W-1:0]        val_q;
  logic signed [DATA_W-1:0] rx_q, ry_q, rz_q;
  logic [4*WT_W-1:0]        wts_q;
  logic [4*SLOT_W-1:0]      idx_q;
  logic [BEAT_W-1:0]        beat_d, beat_q;

  logic                     en, accept, last_beat, out_vld;
  logic [WT_W-1:0]          w_raw, w_clip;
  logic [SLOT_W-1:0]        rd_slot;
  logic                     we, re;
  beat_t                    issue, x_beat;
  bone_row_t                row;
  logic [WT_W-1:0]          x_w;
  logic [3:0][DATA_W-1:0]   x_lane, res;

  assign en        = !out_vld || out_ready_i;
  assign last_beat = (cmd_q == CMD_LOAD) || (beat_q == BEAT_W'(INFLUENCES - 1));
  assign in_ready_o = !hold_q || (en && last_beat);
  assign accept    = in_valid_i && in_ready_o;

  assign w_raw   = wts_q[beat_q*WT_W +: WT_W];
  assign rd_slot = idx_q[beat_q*SLOT_W +: SLOT_W];
  always_comb begin
    w_clip = (w_raw > WEIGHT_ONE) ? WEIGHT_ONE : w_raw;
    if ({1'b0, rd_slot} >= (SLOT_W+1)'(BONE_SLOTS)) begin
      w_clip = '0;
    end
  end

  assign we = en && hold_q && (cmd_q == CMD_LOAD)
              && ({1'b0, slot_q} < (SLOT_W+1)'(BONE_SLOTS)) && (wsel_q <= MARGIN_WORD);
  assign re = en && hold_q && (cmd_q == CMD_SKIN);

  assign issue.vld   = hold_q && (cmd_q == CMD_SKIN);
  assign issue.first = (beat_q == '0);
  assign issue.last  = last_beat;

  always_comb begin
    beat_d = beat_q;
    if (en && hold_q) begin
      beat_d = last_beat ? '0 : beat_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b0;
      beat_q <= '0;
    end else begin
      beat_q <= beat_d;
      if (accept) begin
        hold_q <= 1'b1;
      end else if (en && last_beat) begin
        hold_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= cmd_e'(command_i);
      slot_q <= bone_slot_i;
      wsel_q <= word_select_i;
      val_q  <= word_value_i;
      rx_q   <= rest_x_i;
      ry_q   <= rest_y_i;
      rz_q   <= rest_z_i;
      wts_q  <= weights_packed_i;
      idx_q  <= bone_indices_packed_i;
    end
  end

  lbs_bone_table u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .wslot_i (slot_q),
    .wword_i (wsel_q),
    .wdata_i (val_q),
    .re_i    (re),
    .rslot_i (rd_slot),
    .rdata_o (row)
  );

  lbs_xform u_xform (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .beat_i   (issue),
    .weight_i (w_clip),
    .pos_x_i  (rx_q),
    .pos_y_i  (ry_q),
    .pos_z_i  (rz_q),
    .row_i    (row),
    .beat_o   (x_beat),
    .weight_o (x_w),
    .lane_o   (x_lane)
  );

  lbs_blend u_blend (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .beat_i    (x_beat),
    .weight_i  (x_w),
    .lane_i    (x_lane),
    .out_vld_o (out_vld),
    .out_o     (res)
  );

  assign out_valid_o      = out_vld;
  assign skinned_x_o      = res[0];
  assign skinned_y_o      = res[1];
  assign skinned_z_o      = res[2];
  assign blended_margin_o = res[3];

  a_beat_only_skin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (beat_q != '0) |-> (hold_q && cmd_q == CMD_SKIN))
    else $error("beat counter running without a skin word");

  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(beat_q))
    else $error("beat advanced during stall");

  a_load_one_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hold_q && cmd_q == CMD_LOAD && en) |=> (beat_q == '0))
    else $error("load took more than one beat");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(we && re))
    else $error("table read and write in one cycle");

endmodule

>>> rtl/lbs_bone_table.sv
`timescale 1ns / 1ps
module lbs_bone_table import lbs_pkg::*; (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [SLOT_W-1:0] wslot_i,
  input  logic [WSEL_W-1:0] wword_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [SLOT_W-1:0] rslot_i,
  output bone_row_t         rdata_o
);

  bone_row_t mem [BONE_SLOTS];
  bone_row_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wslot_i][wword_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[rslot_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/lbs_xform.sv
`timescale 1ns / 1ps
module lbs_xform import lbs_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  beat_t                    beat_i,
  input  logic [WT_W-1:0]          weight_i,
  input  logic signed [DATA_W-1:0] pos_x_i,
  input  logic signed [DATA_W-1:0] pos_y_i,
  input  logic signed [DATA_W-1:0] pos_z_i,
  input  bone_row_t                row_i,
  output beat_t                    beat_o,
  output logic [WT_W-1:0]          weight_o,
  output logic [3:0][DATA_W-1:0]   lane_o
);

  // s1: aligned with the table read data
  beat_t                    s1_q, s2_q, s3_q;
  logic [WT_W-1:0]          w1_q, w2_q, w3_q;
  logic signed [DATA_W-1:0] p1_q [3];
  // s2: nine floored products, translation, margin
  logic signed [63:0]       prod_d [9];
  logic signed [63:0]       prod_q [9];
  logic [3:0][DATA_W-1:0]   tm2_q;
  // s3: saturated x/y/z lanes, margin word passed through
  logic [3:0][DATA_W-1:0]   lane_d, lane_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        prod_d[3*c+r] = (64'($signed(row_i[3*c+r])) * 64'(p1_q[c])) >>> FRAC_BITS;
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      lane_d[r] = sat32(prod_q[r] + prod_q[3+r] + prod_q[6+r]
                        + 64'($signed(tm2_q[r])));
    end
    lane_d[3] = tm2_q[3];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
      s3_q <= '0;
    end else if (en_i) begin
      s1_q <= beat_i;
      s2_q <= s1_q;
      s3_q <= s2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      w1_q     <= weight_i;
      p1_q[0]  <= pos_x_i;
      p1_q[1]  <= pos_y_i;
      p1_q[2]  <= pos_z_i;
      w2_q     <= w1_q;
      prod_q   <= prod_d;
      tm2_q[0] <= row_i[9];
      tm2_q[1] <= row_i[10];
      tm2_q[2] <= row_i[11];
      tm2_q[3] <= row_i[MTX_WORDS];
      w3_q     <= w2_q;
      lane_q   <= lane_d;
    end
  end

  assign beat_o   = s3_q;
  assign weight_o = w3_q;
  assign lane_o   = lane_q;

endmodule

>>> rtl/lbs_blend.sv
`timescale 1ns / 1ps
module lbs_blend import lbs_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  beat_t                  beat_i,
  input  logic [WT_W-1:0]        weight_i,
  input  logic [3:0][DATA_W-1:0] lane_i,
  output logic                   out_vld_o,
  output logic [3:0][DATA_W-1:0] out_o
);

  beat_t                   s4_q;
  logic signed [PROD_W-1:0] prod_q [4];
  logic signed [ACC_W-1:0]  acc_d [4];
  logic signed [ACC_W-1:0]  acc_q [4];
  logic [3:0][DATA_W-1:0]   out_d, out_q;
  logic                     out_vld_q;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      acc_d[l] = (s4_q.first ? '0 : acc_q[l]) + ACC_W'(prod_q[l]);
      out_d[l] = sat32(64'(acc_d[l] >>> WEIGHT_FRAC));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_q      <= '0;
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      s4_q      <= beat_i;
      out_vld_q <= s4_q.vld && s4_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < 4; l++) begin
        prod_q[l] <= PROD_W'($signed(lane_i[l])) * PROD_W'($signed({1'b0, weight_i}));
      end
      if (s4_q.vld) begin
        acc_q <= acc_d;
      end
      if (s4_q.vld && s4_q.last) begin
        out_q <= out_d;
      end
    end
  end

  assign out_vld_o = out_vld_q;
  assign out_o     = out_q;

endmodule
